[hw/rtl/ftcjb_pkg.sv]
// Package for the frame-tagged command jitter buffer.
// Holds sizes, request/status codes, payload structs and the ring index helper.
// No dependencies.
package ftcjb_pkg;

    localparam int DEPTH   = 64;                   // ring entries, 2..4096
    localparam int AW      = $clog2(DEPTH);        // ring index width
    localparam int CW      = $clog2(DEPTH + 1);    // entry count width, holds DEPTH
    localparam int FRAME_W = 16;
    localparam int ANGLE_W = 8;
    localparam int SPEED_W = 8;
    localparam int ACT_W   = 4;
    localparam int CMD_W   = ANGLE_W + SPEED_W + ACT_W;

    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_TAKE = 2'd1;
    localparam logic [1:0] FUNC_FIND = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] PUT_STORED = 2'd0;
    localparam logic [1:0] PUT_SEQ    = 2'd1;
    localparam logic [1:0] PUT_FULL   = 2'd2;

    localparam logic [ANGLE_W-1:0] LAST_ANGLE_RST = ANGLE_W'(128);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [SPEED_W-1:0] speed;
        logic [ACT_W-1:0]   action;
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       matched;
        logic [1:0] put_status;
    } res_t;

    // Decisions taken when a request is accepted; state is stable until it retires.
    typedef struct packed {
        logic [1:0]         func;
        logic [FRAME_W-1:0] frame;
        logic               older;
        logic               hit;
        logic               empty;
        logic [1:0]         put_status;
        logic [CW-1:0]      removed;
        logic [AW-1:0]      wr_addr;
        logic [AW-1:0]      next_rp;
    } plan_t;

    // base < DEPTH and inc <= DEPTH, so one conditional subtract wraps the sum.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] inc);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(inc);
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

[hw/rtl/ftcjb_in_if.sv]
// Request channel of the jitter buffer: valid/ready plus request payload.
// Depends on ftcjb_pkg.
interface ftcjb_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [ftcjb_pkg::FRAME_W-1:0] frame;
    logic [ftcjb_pkg::ANGLE_W-1:0] cmd_angle;
    logic [ftcjb_pkg::SPEED_W-1:0] cmd_speed;
    logic [ftcjb_pkg::ACT_W-1:0]   cmd_action;

    modport source (output valid, func, frame, cmd_angle, cmd_speed, cmd_action,
                    input ready);
    modport sink (input valid, func, frame, cmd_angle, cmd_speed, cmd_action,
                  output ready);
endinterface

[hw/rtl/ftcjb_out_if.sv]
// Result channel of the jitter buffer: valid/ready plus result payload.
// Depends on ftcjb_pkg.
interface ftcjb_out_if;
    logic                          valid;
    logic                          ready;
    logic [ftcjb_pkg::ANGLE_W-1:0] out_angle;
    logic [ftcjb_pkg::SPEED_W-1:0] out_speed;
    logic [ftcjb_pkg::ACT_W-1:0]   out_action;
    logic                          matched;
    logic [1:0]                    put_status;

    modport source (output valid, out_angle, out_speed, out_action, matched, put_status,
                    input ready);
    modport sink (input valid, out_angle, out_speed, out_action, matched, put_status,
                  output ready);
endinterface

[hw/rtl/ftcjb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftcjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/ftcjb_plan.sv]
// Request decode: wrap-aware frame offset, hit test, ring addresses, put status.
// Depends on ftcjb_pkg.
module ftcjb_plan (
    input  logic [1:0]                    func,
    input  logic [ftcjb_pkg::FRAME_W-1:0] frame,
    input  logic [ftcjb_pkg::AW-1:0]      rp,
    input  logic [ftcjb_pkg::CW-1:0]      cnt,
    input  logic [ftcjb_pkg::FRAME_W-1:0] first,
    output ftcjb_pkg::plan_t              plan,
    output logic [ftcjb_pkg::AW-1:0]      rd_addr
);

    logic [ftcjb_pkg::FRAME_W-1:0] diff;
    logic [ftcjb_pkg::CW-1:0]      rd_ofs;
    logic                          older;
    logic                          hit;
    logic                          empty;

    assign diff  = frame - first;
    assign older = diff[ftcjb_pkg::FRAME_W-1];
    assign empty = (cnt == '0);
    assign hit   = !older && (diff < ftcjb_pkg::FRAME_W'(cnt));

    // A hit reads its own entry; a miss reads the newest one.
    assign rd_ofs  = hit ? diff[ftcjb_pkg::CW-1:0]
                         : (empty ? '0 : cnt - ftcjb_pkg::CW'(1));
    assign rd_addr = ftcjb_pkg::ring_add(rp, rd_ofs);

    always_comb
    begin
        plan.func    = func;
        plan.frame   = frame;
        plan.older   = older;
        plan.hit     = hit;
        plan.empty   = empty;
        plan.removed = hit ? diff[ftcjb_pkg::CW-1:0] + ftcjb_pkg::CW'(1) : cnt;
        plan.wr_addr = ftcjb_pkg::ring_add(rp, cnt);
        plan.next_rp = ftcjb_pkg::ring_add(rp, plan.removed);
        if (!empty && ((first + ftcjb_pkg::FRAME_W'(cnt)) != frame))
        begin
            plan.put_status = ftcjb_pkg::PUT_SEQ;
        end
        else if (cnt == ftcjb_pkg::CW'(ftcjb_pkg::DEPTH))
        begin
            plan.put_status = ftcjb_pkg::PUT_FULL;
        end
        else
        begin
            plan.put_status = ftcjb_pkg::PUT_STORED;
        end
    end

endmodule

[hw/rtl/frame_tagged_command_jitter_buffer.sv]
// Frame-tagged command jitter buffer: ring store, request decode, result stage.
// Depends on ftcjb_pkg, ftcjb_in_if, ftcjb_out_if, ftcjb_ram, ftcjb_plan.
// An accepted request is held with its plan, then retired into the output register
// once that is free or being read; no new request is taken while one is in flight.
// A finished result waits in the output register while the next request is taken.
// Reset clears count, read position and first frame; last command = angle 128.
module frame_tagged_command_jitter_buffer (
    input  logic               clk,
    input  logic               rst_n,
    ftcjb_in_if.sink           cmd_in,
    ftcjb_out_if.source        res_out
);

    // ring bookkeeping
    logic [ftcjb_pkg::AW-1:0]      rp_reg, rp_next;
    logic [ftcjb_pkg::CW-1:0]      cnt_reg, cnt_next;
    logic [ftcjb_pkg::FRAME_W-1:0] first_reg, first_next;
    ftcjb_pkg::cmd_t               last_reg, last_next;

    // request in flight: held from accept until it retires
    logic                          busy_reg;
    ftcjb_pkg::plan_t              plan, plan_reg;
    ftcjb_pkg::cmd_t               cmd_reg;
    logic [ftcjb_pkg::AW-1:0]      rd_addr;
    ftcjb_pkg::cmd_t               rd_cmd;

    // output register
    logic                          out_valid_reg;
    ftcjb_pkg::res_t               out_reg, res;

    logic                          accept;
    logic                          finish;
    logic                          ram_we;

    assign cmd_in.ready = !busy_reg;
    assign accept       = cmd_in.valid && cmd_in.ready;
    // retire once the output slot is free or being emptied this cycle
    assign finish       = busy_reg && (!out_valid_reg || res_out.ready);

    // decode against the current state; state only moves when the request retires
    ftcjb_plan u_plan (
        .func    (cmd_in.func),
        .frame   (cmd_in.frame),
        .rp      (rp_reg),
        .cnt     (cnt_reg),
        .first   (first_reg),
        .plan    (plan),
        .rd_addr (rd_addr)
    );

    // read at accept, write (put) at retire: never in the same cycle
    ftcjb_ram #(
        .WIDTH (ftcjb_pkg::CMD_W),
        .DEPTH (ftcjb_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (plan_reg.wr_addr),
        .wdata (cmd_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_cmd)
    );

    // result and state update for the request being retired
    always_comb
    begin
        res        = '0;
        ram_we     = 1'b0;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        last_next  = last_reg;
        case (plan_reg.func)
            ftcjb_pkg::FUNC_PUT:
            begin
                res.put_status = plan_reg.put_status;
                if (plan_reg.put_status == ftcjb_pkg::PUT_STORED)
                begin
                    ram_we   = finish;
                    cnt_next = cnt_reg + ftcjb_pkg::CW'(1);
                    if (plan_reg.empty)
                    begin
                        first_next = plan_reg.frame;
                    end
                end
            end
            ftcjb_pkg::FUNC_TAKE:
            begin
                if (plan_reg.older || (!plan_reg.hit && plan_reg.empty))
                begin
                    // stale frame, or nothing stored: repeat the last command
                    res.cmd = last_reg;
                end
                else
                begin
                    // drop everything up to the target (or all on a miss)
                    res.cmd     = rd_cmd;
                    res.matched = plan_reg.hit;
                    last_next   = rd_cmd;
                    rp_next     = plan_reg.next_rp;
                    cnt_next    = cnt_reg - plan_reg.removed;
                    first_next  = first_reg + ftcjb_pkg::FRAME_W'(plan_reg.removed);
                end
            end
            ftcjb_pkg::FUNC_FIND:
            begin
                if (plan_reg.older || (!plan_reg.hit && plan_reg.empty))
                begin
                    res.cmd = last_reg;
                end
                else
                begin
                    // hit returns the entry, miss returns the newest entry
                    res.cmd     = rd_cmd;
                    res.matched = plan_reg.hit;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg          <= '0;
            cnt_reg         <= '0;
            first_reg       <= '0;
            last_reg.angle  <= ftcjb_pkg::LAST_ANGLE_RST;
            last_reg.speed  <= '0;
            last_reg.action <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            if (finish)
            begin
                rp_reg        <= rp_next;
                cnt_reg       <= cnt_next;
                first_reg     <= first_next;
                last_reg      <= last_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg       <= plan;
            cmd_reg.angle  <= cmd_in.cmd_angle;
            cmd_reg.speed  <= cmd_in.cmd_speed;
            cmd_reg.action <= cmd_in.cmd_action;
        end
        if (finish)
        begin
            out_reg <= res;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.out_angle  = out_reg.cmd.angle;
    assign res_out.out_speed  = out_reg.cmd.speed;
    assign res_out.out_action = out_reg.cmd.action;
    assign res_out.matched    = out_reg.matched;
    assign res_out.put_status = out_reg.put_status;

    // occupancy never passes the ring size, read position stays on the ring
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= ftcjb_pkg::CW'(ftcjb_pkg::DEPTH)) &&
        (ftcjb_pkg::CW'(rp_reg) < ftcjb_pkg::CW'(ftcjb_pkg::DEPTH)))
        else $error("ring occupancy or read position out of range");

    // an accepted request is always in flight on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted request not in flight");

    // a matching take always shrinks the buffer
    a_take_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (plan_reg.func == ftcjb_pkg::FUNC_TAKE) && plan_reg.hit)
        |=> (cnt_reg < $past(cnt_reg)))
        else $error("take hit did not remove entries");

    // a stored put grows the buffer by exactly one
    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (plan_reg.func == ftcjb_pkg::FUNC_PUT) &&
         (plan_reg.put_status == ftcjb_pkg::PUT_STORED))
        |=> (cnt_reg == $past(cnt_reg) + ftcjb_pkg::CW'(1)))
        else $error("stored put did not add one entry");

    // a match is only reported for take or find, never with a put status
    a_match_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.matched) |-> (res_out.put_status == ftcjb_pkg::PUT_STORED))
        else $error("matched result carries a put status");

endmodule
